/* rtl/shbs_pkg.sv */
`timescale 1ns / 1ps
package shbs_pkg;

  localparam int HALF_W    = 64;
  localparam int KEY_W     = 2 * HALF_W;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 8;

  // request kinds carried on tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_HOLD
  } state_t;

endpackage

/* rtl/shbs_mem.sv */
`timescale 1ns / 1ps
module shbs_mem #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
  input  logic [shbs_pkg::KEY_W-1:0]           wr_data,
  input  logic                                 rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
  output logic [shbs_pkg::KEY_W-1:0]           rd_data
);
  import shbs_pkg::*;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/shbs_ctrl.sv */
`timescale 1ns / 1ps
module shbs_ctrl #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [shbs_pkg::KEY_W-1:0]         key_in,
  input  logic [shbs_pkg::CNT_W-1:0]         entry_count,
  output logic                               idle,
  output logic                               rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
  input  logic [shbs_pkg::KEY_W-1:0]         rd_data,
  output logic                               m_valid,
  input  logic                               m_ready,
  output logic                               found
);
  import shbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

  state_t         state, state_next;
  logic [KEY_W-1:0] key;
  logic [CW-1:0]  low, low_next;
  logic [CW-1:0]  hi_x, hi_x_next;     // one past the upper bound
  logic [AW-1:0]  mid, mid_next;
  logic           found_pend, found_pend_next;
  logic           m_valid_next, found_next;

  logic [NW-1:0]  cnt_ext;
  logic [CW-1:0]  n_sat, mid0;
  logic [CW-1:0]  mid_w, low_g, mid_l, mid_g;
  logic           cont_l, cont_g, key_eq, key_lt, out_free;

  assign cnt_ext = NW'(entry_count);
  assign n_sat   = (cnt_ext > DEPTH_N) ? DEPTH_N[CW-1:0] : cnt_ext[CW-1:0];
  assign mid0    = (n_sat - CW'(1)) >> 1;

  assign key_eq  = (rd_data == key);
  assign key_lt  = (key < rd_data);

  // next midpoint for both outcomes, worked out alongside the compare
  assign mid_w   = {1'b0, mid};
  assign cont_l  = (low < mid_w);
  assign mid_l   = low + ((mid_w - CW'(1) - low) >> 1);
  assign low_g   = mid_w + CW'(1);
  assign cont_g  = (low_g < hi_x);
  assign mid_g   = low_g + ((hi_x - CW'(1) - low_g) >> 1);

  assign out_free = !m_valid || m_ready;
  assign idle     = (state == ST_IDLE);
  assign rd_addr  = mid_next;

  always_comb begin
    state_next      = state;
    low_next        = low;
    hi_x_next       = hi_x;
    mid_next        = mid;
    found_pend_next = found_pend;
    rd_en           = 1'b0;
    m_valid_next    = m_valid && !m_ready;
    found_next      = found;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          low_next  = '0;
          hi_x_next = n_sat;
          mid_next  = mid0[AW-1:0];
          if (n_sat != '0) begin
            rd_en      = 1'b1;
            state_next = ST_PROBE;
          end else if (out_free) begin
            m_valid_next = 1'b1;
            found_next   = 1'b0;
          end else begin
            found_pend_next = 1'b0;
            state_next      = ST_HOLD;
          end
        end
      end
      ST_PROBE: begin
        if (key_eq || (key_lt && !cont_l) || (!key_lt && !cont_g)) begin
          if (out_free) begin
            m_valid_next = 1'b1;
            found_next   = key_eq;
            state_next   = ST_IDLE;
          end else begin
            found_pend_next = key_eq;
            state_next      = ST_HOLD;
          end
        end else if (key_lt) begin
          hi_x_next = mid_w;
          mid_next  = mid_l[AW-1:0];
          rd_en     = 1'b1;
        end else begin
          low_next  = low_g;
          mid_next  = mid_g[AW-1:0];
          rd_en     = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          found_next   = found_pend;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      m_valid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) begin
      key <= key_in;
    end
    low        <= low_next;
    hi_x       <= hi_x_next;
    mid        <= mid_next;
    found_pend <= found_pend_next;
    found      <= found_next;
  end

endmodule

/* rtl/sorted_hash_table_binary_search.sv */
`timescale 1ns / 1ps
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tuser: func; tdata: load_index, key_high, key_low
// m_axis   out  tdata: found (search requests only)
// cfg      in   cfg_wdata: entry_count
//
// A load request writes the key memory as soon as it is accepted.
// A search makes p probes, p at most ceil(log2(count + 1)), eleven for
// 1024 entries; the single read port of the key memory gives one
// probe per cycle. s_axis_tready is low while a search runs or waits in ST_HOLD.
// rst is synchronous; the key memory is not cleared and entry_count is 0.
// A result waits in the output register; a new request is taken meanwhile.
module sorted_hash_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // load_index [9:0], key_high [73:10], key_low [137:74], zeros above
  input  logic [shbs_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // func [0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // found [0], zeros above
  output logic [shbs_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [shbs_pkg::CNT_W-1:0]           cfg_wdata
);
  import shbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [CNT_W-1:0]  entry_count;
  logic              accept, search_start, idle;
  logic [IDX_W-1:0]  load_index;
  logic [HALF_W-1:0] key_high, key_low;
  logic              wr_en, rd_en, found;
  logic [AW-1:0]     rd_addr;
  logic [KEY_W-1:0]  rd_data;

  assign load_index = s_axis_tdata[IDX_W-1:0];
  assign key_high   = s_axis_tdata[IDX_W +: HALF_W];
  assign key_low    = s_axis_tdata[IDX_W+HALF_W +: HALF_W];

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign search_start  = accept && (s_axis_tuser == FUNC_SEARCH);
  // drop loads beyond the table
  assign wr_en = accept && (s_axis_tuser == FUNC_LOAD) && (32'(load_index) < TABLE_DEPTH);

  assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, found};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  shbs_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(load_index)),
    .wr_data ({key_high, key_low}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  shbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (search_start),
    .key_in      ({key_high, key_low}),
    .entry_count (entry_count),
    .idle        (idle),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .found       (found)
  );

endmodule

/* tb/sorted_hash_table_binary_search_tb.sv */
`timescale 1ns / 1ps
module sorted_hash_table_binary_search_tb;
  import shbs_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  class key_table_board;
    bit [HALF_W-1:0] key_upper [TABLE_DEPTH];
    bit [HALF_W-1:0] key_lower [TABLE_DEPTH];
    int              live_count;
    bit              found_due [$];
    int unsigned     mismatches;

    function void set_count(bit [CNT_W-1:0] value);
      live_count = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    endfunction

    // binary search with signed bounds over the first live_count entries
    function bit lookup_key(bit [KEY_W-1:0] key);
      int lo;
      int hi;
      int mid;
      bit [KEY_W-1:0] probe;
      lo = 0;
      hi = live_count - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        probe = {key_upper[mid], key_lower[mid]};
        if (probe == key) return 1'b1;
        if (key < probe) hi = mid - 1;
        else lo = mid + 1;
      end
      return 1'b0;
    endfunction

    function void note_request(bit func, bit [IDX_W-1:0] idx, bit [KEY_W-1:0] key);
      if (func == FUNC_LOAD) begin
        if (idx < TABLE_DEPTH) begin
          key_upper[idx] = key[KEY_W-1:HALF_W];
          key_lower[idx] = key[HALF_W-1:0];
        end
      end else begin
        found_due.push_back(lookup_key(key));
      end
    endfunction

    function void check_found(bit [M_TDATA_W-1:0] data);
      bit want;
      if (found_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result, found=%0b", $time, data[0]);
        mismatches++;
      end else begin
        want = found_due.pop_front();
        if (data[0] !== want) begin
          if (mismatches < 10)
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, want, data[0]);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return found_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = FUNC_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  key_table_board board;
  int  sender_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_req = 1'b0;

  always #5 clk = ~clk;

  sorted_hash_table_binary_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  function automatic bit [KEY_W-1:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_request(bit func, bit [IDX_W-1:0] idx, bit [KEY_W-1:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, key[HALF_W-1:0], key[KEY_W-1:HALF_W], idx};
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(func, idx, key);
  endtask

  // drop valid, wait for every result, then let a trailing load or search finish
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(bit [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(value);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin sender_idle_pct = 67; rx_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  rx_stall_pct = 67; end
      default: begin sender_idle_pct = 10; rx_stall_pct = 10; end
    endcase
  endtask

  // fill entries 0..count-1, ascending unless scrambled
  task automatic load_table(int count, bit ascending);
    bit [KEY_W-1:0] key;
    int shift;
    shift = $urandom_range(126, 12);
    key = rand_key() >> $urandom_range(127, 1);
    for (int i = 0; i < count; i++) begin
      if (!ascending) key = rand_key();
      else if (i > 0) key = key + (rand_key() >> shift) + 1;
      send_request(FUNC_LOAD, i[IDX_W-1:0], key);
    end
  endtask

  task automatic random_request(int count);
    int r;
    int i;
    bit [KEY_W-1:0] key;
    r = $urandom_range(99);
    i = (count > 0) ? $urandom_range(count - 1) : $urandom_range(TABLE_DEPTH - 1);
    key = {board.key_upper[i], board.key_lower[i]};
    if (r < 8)
      send_request(FUNC_LOAD, i[IDX_W-1:0], rand_key());
    else if (r < 50 && count > 0)
      send_request(FUNC_SEARCH, IDX_W'($urandom), key);
    else if (r < 70 && count > 0)
      send_request(FUNC_SEARCH, IDX_W'($urandom), r[0] ? key + 1 : key - 1);
    else if (r < 76)
      send_request(FUNC_SEARCH, IDX_W'($urandom), r[0] ? '1 : '0);
    else
      send_request(FUNC_SEARCH, IDX_W'($urandom), rand_key());
  endtask

  // result side: check, then decide tready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_found(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    int issued;
    int span;
    int used;
    int pick;
    bit [CNT_W-1:0] count;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: nothing can match
    send_request(FUNC_SEARCH, '0, '0);
    send_request(FUNC_SEARCH, '1, '1);
    send_request(FUNC_LOAD, 10'd0, '0);
    send_request(FUNC_LOAD, 10'd1, {64'd0, {64{1'b1}}});
    send_request(FUNC_LOAD, 10'd2, {64'd1, 64'd0});
    send_request(FUNC_LOAD, 10'd3, {{64{1'b1}}, {63{1'b1}}, 1'b0});
    send_request(FUNC_LOAD, 10'd4, '1);
    send_request(FUNC_LOAD, 10'd1023, {64'h5a5a_a5a5_0f0f_f0f0, 64'h0123_4567_89ab_cdef});
    await_idle();
    write_count(11'd5);
    for (int i = 0; i < 5; i++)
      send_request(FUNC_SEARCH, IDX_W'($urandom), {board.key_upper[i], board.key_lower[i]});
    send_request(FUNC_SEARCH, '0, {64'd0, 64'd1});
    send_request(FUNC_SEARCH, '0, {64'd1, 64'd1});
    send_request(FUNC_SEARCH, '1, {{64{1'b1}}, {62{1'b1}}, 2'b01});
    send_request(FUNC_SEARCH, '1, {64'h8000_0000_0000_0000, 64'd0});
    await_idle();
    write_count(11'd1);
    send_request(FUNC_SEARCH, '0, '0);
    send_request(FUNC_SEARCH, '0, {64'd0, 64'd1});

    phase = 0;
    issued = 0;
    while (issued < 500) begin
      await_idle();
      set_idling(phase % 4);
      case (phase)
        2: count = 11'd1024;
        5: count = 11'd2047;
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) count = 11'd0;
          else if (pick == 1) count = 11'd1;
          else if (pick == 2) count = 11'd2;
          else count = CNT_W'($urandom_range(64, 3));
        end
      endcase
      used = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
      // the full table loaded earlier stays written, so skip a second fill
      if (phase != 5) load_table(used, $urandom_range(5) != 0);
      await_idle();
      write_count(count);
      // long output stall while requests keep coming
      if (phase == 1) hold_req = 1'b1;
      span = $urandom_range(60, 20);
      repeat (span) random_request(used);
      issued += span;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/shbs_pkg.sv
rtl/shbs_mem.sv
rtl/shbs_ctrl.sv
rtl/sorted_hash_table_binary_search.sv
tb/sorted_hash_table_binary_search_tb.sv
